// ===== src/assert_macros.svh =====
// Assertion helpers used by base64_stream_codec.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/b64_pkg.sv =====
`timescale 1ns / 1ps

package b64_pkg;

  localparam int ACC_W  = 12;
  localparam int CNT_W  = 4;
  localparam int SYM_W  = 6;
  localparam int BYTE_W = 8;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  typedef struct packed {
    logic              enc;
    logic [BYTE_W-1:0] d0;
    logic [BYTE_W-1:0] d1;
    logic              two;
    logic              nd;
    logic              last;
  } b64_job_t;

  function automatic logic [BYTE_W-1:0] sym_char(input logic [SYM_W-1:0] v);
    logic [BYTE_W-1:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      sym_char = w + 8'd65;
    end else if (v < 6'd52) begin
      sym_char = w + 8'd71;
    end else if (v < 6'd62) begin
      sym_char = w - 8'd4;
    end else if (v == 6'd62) begin
      sym_char = 8'h2B;
    end else begin
      sym_char = 8'h2F;
    end
  endfunction

  function automatic logic [SYM_W-1:0] sym_value(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] t;
    t = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      t = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      t = c - 8'h47;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      t = c + 8'd4;
    end else if (c == 8'h2B) begin
      t = 8'd62;
    end else if (c == 8'h2F) begin
      t = 8'd63;
    end
    sym_value = t[SYM_W-1:0];
  endfunction

endpackage

// ===== src/b64_front.sv =====
`timescale 1ns / 1ps

module b64_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_mode,
  input  logic                        accept,
  input  logic [b64_pkg::BYTE_W-1:0]  data,
  input  logic                        last,
  output logic                        job_push,
  output b64_pkg::b64_job_t           job
);

  logic                       mode_r, mode_nxt;
  logic [b64_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic [b64_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;

  logic [b64_pkg::ACC_W-1:0]  acc8, acc6, acc_new;
  logic [b64_pkg::CNT_W-1:0]  cnt_new;
  logic [b64_pkg::SYM_W-1:0]  dval;
  logic                       byte_out;

  always_comb begin
    acc8     = {acc_r[3:0], data};
    dval     = b64_pkg::sym_value(data);
    acc6     = {acc_r[5:0], dval};
    job      = '0;
    job.last = last;
    byte_out = 1'b0;
    acc_new  = acc8;
    cnt_new  = '0;
    if (mode_r == b64_pkg::MODE_ENCODE) begin
      job.enc = 1'b1;
      acc_new = acc8;
      unique case (cnt_r)
        4'd2: begin
          job.d0  = {2'b00, acc8[9:4]};
          job.d1  = {2'b00, acc8[3:0], 2'b00};
          job.two = last;
          cnt_new = 4'd4;
        end
        4'd4: begin
          job.d0  = {2'b00, acc8[11:6]};
          job.d1  = {2'b00, acc8[5:0]};
          job.two = 1'b1;
          cnt_new = 4'd0;
        end
        default: begin
          job.d0  = {2'b00, acc8[7:2]};
          job.d1  = {2'b00, acc8[1:0], 4'b0000};
          job.two = last;
          cnt_new = 4'd2;
        end
      endcase
    end else begin
      acc_new = acc6;
      unique case (cnt_r)
        4'd2: begin
          job.d0   = acc6[7:0];
          byte_out = 1'b1;
          cnt_new  = 4'd0;
        end
        4'd4: begin
          job.d0   = acc6[9:2];
          byte_out = 1'b1;
          cnt_new  = 4'd2;
        end
        4'd6: begin
          job.d0   = acc6[11:4];
          byte_out = 1'b1;
          cnt_new  = 4'd4;
        end
        default: begin
          cnt_new = 4'd6;
        end
      endcase
      job.nd = !byte_out;
    end
    job_push = accept && (job.enc || byte_out || last);
  end

  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    if (cfg_we) begin
      mode_nxt = cfg_mode;
      acc_nxt  = '0;
      cnt_nxt  = '0;
    end else if (accept) begin
      acc_nxt = last ? '0 : acc_new;
      cnt_nxt = last ? '0 : cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= b64_pkg::MODE_ENCODE;
      acc_r  <= '0;
      cnt_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ===== src/b64_queue.sv =====
`timescale 1ns / 1ps

module b64_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  b64_pkg::b64_job_t  wr_job,
  output logic               full,
  input  logic               pop,
  output b64_pkg::b64_job_t  rd_job,
  output logic               empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  b64_pkg::b64_job_t mem [DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_job  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== src/b64_back.sv =====
`timescale 1ns / 1ps

module b64_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  b64_pkg::b64_job_t           job,
  input  logic                        q_empty,
  output logic                        q_pop,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [b64_pkg::BYTE_W-1:0]  out_data,
  output logic                        out_no_data,
  output logic                        out_last
);

  logic                       valid_r, valid_nxt;
  logic                       phase_r, phase_nxt;
  logic [b64_pkg::BYTE_W-1:0] data_r, data_nxt;
  logic                       nd_r, nd_nxt;
  logic                       last_r, last_nxt;
  logic [b64_pkg::BYTE_W-1:0] sel;
  logic                       load;

  always_comb begin
    load      = !q_empty && (!valid_r || out_pop);
    sel       = phase_r ? job.d1 : job.d0;
    data_nxt  = job.enc ? b64_pkg::sym_char(sel[b64_pkg::SYM_W-1:0]) : sel;
    nd_nxt    = job.nd;
    last_nxt  = job.last && (phase_r || !job.two);
    q_pop     = load && (phase_r || !job.two);
    phase_nxt = load ? (!phase_r && job.two) : phase_r;
    valid_nxt = load ? 1'b1 : (out_pop ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
      nd_r   <= nd_nxt;
      last_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  assign out_empty   = !valid_r;
  assign out_data    = data_r;
  assign out_no_data = nd_r;
  assign out_last    = last_r;

endmodule

// ===== src/base64_stream_codec.sv =====
`timescale 1ns / 1ps

// Unpadded Base64 stream codec (A-Z a-z 0-9 + /). cfg_mode 0 encodes bytes
// to symbols, 1 decodes symbols to bytes; any cfg transfer also drops a
// partial message. Input items are taken one per cycle, unless in_full, into
// a job queue of QUEUE_DEPTH entries; the result port drives one result per
// cycle while out_pop takes them, so an item giving two results (every third
// byte when encoding, or a final byte with leftover bits) occupies the result
// port for both results in turn. Encode is bounded by the result port (3
// bytes give 4 results); decode sustains 1 symbol per cycle. Results pass
// the job queue, then the b64_back output register. A last item that yields
// no byte produces one marker result with out_no_data and out_last set.
module base64_stream_codec #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_mode,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_data,
  input  logic       in_last,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_data,
  output logic       out_no_data,
  output logic       out_last
);

`include "assert_macros.svh"

  b64_pkg::b64_job_t fr_job, q_job;
  logic              fr_push, q_full, q_empty, q_pop, in_accept;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;
  assign in_accept = in_push && !q_full;

  b64_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_mode (cfg_mode),
    .accept   (in_accept),
    .data     (in_data),
    .last     (in_last),
    .job_push (fr_push),
    .job      (fr_job)
  );

  b64_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (fr_push),
    .wr_job (fr_job),
    .full   (q_full),
    .pop    (q_pop),
    .rd_job (q_job),
    .empty  (q_empty)
  );

  b64_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .job         (q_job),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_data    (out_data),
    .out_no_data (out_no_data),
    .out_last    (out_last)
  );

  `ASSERT_NEXT(a_back_refill, clk, rst_n, !q_empty && out_empty, !out_empty)
  `ASSERT_IMPLIES(a_marker_form, clk, rst_n, !out_empty && out_no_data, out_last && out_data == '0)

endmodule
